/* rtl/tfcs_pkg.sv */
`default_nettype none

package tfcs_pkg;

    localparam int SLOTS_DEF   = 128;
    localparam int TTL_W       = 8;
    localparam int ID_W        = 32;
    localparam int SLOT_W      = 7;
    localparam int STATUS_W    = 3;
    localparam int MODE_W      = 2;

    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(4);

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOAD_FAIL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   file_id;
        logic              load_ok;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_TICK,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic flush;
        logic scan;
        logic hit_upd;
        logic resolve;
        logic tick_upd;
        logic set_done;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/tfcs_ctrl.sv */
`default_nettype none

module tfcs_ctrl
    import tfcs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_in   i_in,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in.mode == MODE_LOOKUP) begin
                        n_state = S_SCAN;
                    end else if (i_in.mode == MODE_TICK) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    n_state = S_FINISH;
                end else if (i_stat.last) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_RESOLVE: begin
                n_state = S_FINISH;
            end
            S_TICK: begin
                if (i_stat.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // flush and the unused mode answer at once
                    if (i_in.mode != MODE_LOOKUP && i_in.mode != MODE_TICK) begin
                        o_cmd.set_done = 1'b1;
                        o_cmd.flush    = (i_in.mode == MODE_FLUSH);
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan    = 1'b1;
                o_cmd.hit_upd = i_stat.hit;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
            end
            S_TICK: begin
                o_cmd.scan     = 1'b1;
                o_cmd.tick_upd = 1'b1;
                o_cmd.set_done = i_stat.last;
            end
            S_FINISH: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tfcs_dpath.sv */
`default_nettype none

module tfcs_dpath
    import tfcs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in              i_in,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    input  wire logic             i_cfg_valid,
    input  wire logic [TTL_W-1:0] i_cfg_data,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output t_out                  o_out
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;

    logic [ID_W-1:0]  r_tag_mem [SLOTS];
    logic [TTL_W-1:0] r_ttl_mem [SLOTS];

    logic [TTL_W-1:0] r_ttl_reload;
    logic [ID_W-1:0]  r_id;
    logic             r_load_ok;
    logic [CNT_W-1:0] r_idx;
    logic             r_q_vld;
    logic [IDX_W-1:0] r_q_idx;
    logic [ID_W-1:0]  r_tag_q;
    logic [TTL_W-1:0] r_ttl_q;
    logic             r_free_vld;
    logic [IDX_W-1:0] r_free_idx;
    logic [SLOTS-1:0] r_valid;
    t_out             r_res;
    logic             r_out_vld;
    t_out             r_out;

    logic                    issue;
    logic [IDX_W-1:0]        rd_addr;
    logic                    q_valid_bit;
    logic                    install;
    logic                    ttl_dec;
    logic                    expire;
    logic                    tag_we;
    logic                    ttl_we;
    logic [IDX_W-1:0]        ttl_waddr;
    logic [TTL_W-1:0]        ttl_wdata;
    logic [IDX_W+SLOT_W-1:0] q_slot_ext;
    logic [IDX_W+SLOT_W-1:0] free_slot_ext;

    assign issue       = i_cmd.scan && (r_idx < CNT_W'(SLOTS));
    assign rd_addr     = r_idx[IDX_W-1:0];
    assign q_valid_bit = r_valid[r_q_idx];
    assign install     = i_cmd.resolve && r_free_vld && r_load_ok;
    assign ttl_dec     = i_cmd.tick_upd && r_q_vld && (r_ttl_q != '0);
    assign expire      = i_cmd.tick_upd && r_q_vld && (r_ttl_q == '0) && q_valid_bit;
    assign tag_we      = install;

    // slot field carries the index modulo 128
    assign q_slot_ext    = {{SLOT_W{1'b0}}, r_q_idx};
    assign free_slot_ext = {{SLOT_W{1'b0}}, r_free_idx};

    assign o_stat.hit      = r_q_vld && q_valid_bit && (r_tag_q == r_id);
    assign o_stat.last     = r_q_vld && (r_q_idx == IDX_W'(SLOTS - 1));
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    always_comb begin
        ttl_we    = 1'b0;
        ttl_waddr = r_q_idx;
        ttl_wdata = r_ttl_reload;
        priority if (i_cmd.hit_upd) begin
            ttl_we = 1'b1;
        end else if (install) begin
            ttl_we    = 1'b1;
            ttl_waddr = r_free_idx;
        end else if (ttl_dec) begin
            ttl_we    = 1'b1;
            ttl_wdata = r_ttl_q - TTL_W'(1);
        end else begin
            ttl_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[r_free_idx] <= r_id;
        end
        r_tag_q <= r_tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ttl_we) begin
            r_ttl_mem[ttl_waddr] <= ttl_wdata;
        end
        r_ttl_q <= r_ttl_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_reload <= TTL_RESET;
        end else if (i_cfg_valid) begin
            r_ttl_reload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id      <= i_in.file_id;
            r_load_ok <= i_in.load_ok;
        end
        r_q_idx <= rd_addr;
        if (i_cmd.scan && r_q_vld && !q_valid_bit && !r_free_vld) begin
            r_free_idx <= r_q_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_q_vld    <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_q_vld <= issue;
            if (i_cmd.scan && r_q_vld && !q_valid_bit) begin
                r_free_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.flush) begin
            r_valid <= '0;
        end else if (install) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (expire) begin
            r_valid[r_q_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.hit_upd) begin
            r_res.status <= ST_HIT;
            r_res.slot   <= q_slot_ext[SLOT_W-1:0];
        end else if (i_cmd.resolve) begin
            priority if (!r_free_vld) begin
                r_res.status <= ST_NO_SPACE;
                r_res.slot   <= '0;
            end else if (!r_load_ok) begin
                r_res.status <= ST_LOAD_FAIL;
                r_res.slot   <= '0;
            end else begin
                r_res.status <= ST_LOADED;
                r_res.slot   <= free_slot_ext[SLOT_W-1:0];
            end
        end else if (i_cmd.set_done) begin
            r_res.status <= ST_DONE;
            r_res.slot   <= '0;
        end else begin
            r_res <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_valid == '0))
        else $error("valid bits survive a flush");

    a_install_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        install |=> r_valid[$past(r_free_idx)])
        else $error("installed slot not marked valid");

    a_hit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_upd |-> (r_q_vld && q_valid_bit))
        else $error("ttl reload on a slot that was not read or not valid");

    a_free_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.resolve && r_free_vld |-> !r_valid[r_free_idx])
        else $error("chosen free slot is occupied");

endmodule

`default_nettype wire

/* rtl/ttl_file_cache_slots_unit.sv */
// a lookup scans the slots until a hit, then resolves a miss into a load or a failure; a tick
// scans every slot, and a flush or the spare mode answers without a scan
// throughput: one item at a time, set by the one-slot-per-cycle scan through the tag and
// ttl memories
// reset: synchronous active low; clears all valid marks at once and sets ttl_reload to 4,
// no clearing pass, so the block takes an item in the first cycle after reset
`default_nettype none

module ttl_file_cache_slots_unit
    import tfcs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in              i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [TTL_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tfcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tfcs_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* tb/ttl_file_cache_slots_unit_tb.sv */
`timescale 1ns / 100ps

module ttl_file_cache_slots_unit_tb;
    import tfcs_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int POOL_N = 16;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in              i_in = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [TTL_W-1:0] i_cfg_data = '0;

    ttl_file_cache_slots_unit #(.SLOTS(NSLOT)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the slot directory
    logic [ID_W-1:0]  tag_copy [NSLOT];
    bit               live_copy [NSLOT];
    logic [TTL_W-1:0] ttl_copy [NSLOT];
    logic [TTL_W-1:0] reload_copy;

    t_in  requests_pending[$];
    t_out answers_due[$];
    logic [ID_W-1:0] id_pool [POOL_N];

    int   items_queued = 0;
    int   items_sent = 0;
    int   fault_cnt = 0;
    int   status_seen [8];
    int   burst_left = 1;
    int   gap_left = 0;
    bit   in_offer;
    t_out due;
    logic [11:0] stall_cnt = '0;
    int   stall_kind = 0;
    int   quiet = 0;
    int   ttl_plan [5];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out directory_step(t_in req);
        t_out ans;
        int   free_idx;
        bit   found;
        ans.status = ST_DONE;
        ans.slot = '0;
        free_idx = -1;
        found = 1'b0;
        case (req.mode)
            MODE_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (ttl_copy[i] != 0) begin
                        ttl_copy[i] = ttl_copy[i] - 1'b1;
                    end else if (live_copy[i]) begin
                        live_copy[i] = 1'b0;
                        tag_copy[i] = '0;
                    end
                end
            end
            MODE_FLUSH: begin
                for (int i = 0; i < NSLOT; i++) begin
                    live_copy[i] = 1'b0;
                    tag_copy[i] = '0;
                    ttl_copy[i] = '0;
                end
            end
            MODE_LOOKUP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!found) begin
                        if (live_copy[i]) begin
                            if (tag_copy[i] == req.file_id) begin
                                found = 1'b1;
                                ttl_copy[i] = reload_copy;
                                ans.status = ST_HIT;
                                ans.slot = SLOT_W'(i);
                            end
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                end
                if (!found) begin
                    if (free_idx < 0) begin
                        ans.status = ST_NO_SPACE;
                    end else if (!req.load_ok) begin
                        ans.status = ST_LOAD_FAIL;
                    end else begin
                        tag_copy[free_idx] = req.file_id;
                        live_copy[free_idx] = 1'b1;
                        ttl_copy[free_idx] = reload_copy;
                        ans.status = ST_LOADED;
                        ans.slot = SLOT_W'(free_idx);
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic push_req(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                            input logic ok);
        t_in req;
        req.mode = m;
        req.file_id = id;
        req.load_ok = ok;
        requests_pending.push_back(req);
        items_queued++;
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_N; i++) id_pool[i] = $urandom;
        if ($urandom_range(0, 1)) begin
            id_pool[0] = '0;
            id_pool[1] = '1;
        end
        // ids one bit apart from each other
        id_pool[2] = id_pool[3] ^ (32'h1 << $urandom_range(0, 31));
    endtask

    // load past the directory size, then probe residents and newcomers
    task automatic fill_episode();
        logic [ID_W-1:0] resident[$];
        logic [ID_W-1:0] id;
        if ($urandom_range(0, 1)) push_req(MODE_FLUSH, $urandom, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(130, 150)) begin
            id = $urandom;
            resident.push_back(id);
            push_req(MODE_LOOKUP, id, $urandom_range(0, 19) != 0);
        end
        repeat (12) begin
            if ($urandom_range(0, 1))
                id = resident[$urandom_range(0, resident.size() - 1)];
            else
                id = $urandom;
            push_req(MODE_LOOKUP, id, 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 3))
            push_req(MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
        repeat (8) push_req(MODE_LOOKUP, $urandom, 1'b1);
    endtask

    task automatic mixed_episode();
        int kind;
        int r;
        kind = $urandom_range(0, 4);
        if (kind == 0) begin
            repeat ($urandom_range(5, 15))
                push_req(MODE_W'($urandom_range(0, 3)), $urandom,
                         1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(20, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    push_req(MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
                else if (r < 14)
                    push_req(MODE_FLUSH, $urandom, 1'($urandom_range(0, 1)));
                else
                    push_req(MODE_LOOKUP, id_pool[$urandom_range(0, POOL_N - 1)],
                             $urandom_range(0, 9) != 0);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (requests_pending.size() != 0 || i_in_valid || answers_due.size() != 0);
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        reload_copy = value;
        i_cfg_valid <= 1'b0;
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                answers_due.push_back(directory_step(i_in));
                items_sent++;
                in_offer = 1'b0;
            end
            if (!in_offer && requests_pending.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    i_in <= requests_pending.pop_front();
                    in_offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: gap_left = 0;
                            5, 6, 7: gap_left = $urandom_range(1, 10);
                            default: gap_left = $urandom_range(20, 160);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_in_valid <= in_offer;
        end
    end

    // result checker, the receiver stall pattern is picked anew each time the low byte of stall_cnt wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got status %0d slot %0d",
                             $time, o_out.status, o_out.slot);
                    fault_cnt++;
                end else begin
                    due = answers_due.pop_front();
                    if (o_out.status !== due.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, due.status, o_out.status);
                        fault_cnt++;
                    end
                    if (o_out.slot !== due.slot) begin
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, due.slot, o_out.slot);
                        fault_cnt++;
                    end
                    status_seen[due.status]++;
                end
            end
            stall_cnt <= stall_cnt + 1'b1;
            if (stall_cnt[7:0] == 8'hff) stall_kind <= $urandom_range(0, 3);
            case (stall_kind)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= (stall_cnt[1:0] == 2'd0);
                2: i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= !stall_cnt[4];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("[ttl_file_cache_slots_unit] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tag_copy[i] = '0;
            live_copy[i] = 1'b0;
            ttl_copy[i] = '0;
        end
        foreach (status_seen[i]) status_seen[i] = 0;
        reload_copy = TTL_RESET;
        ttl_plan = '{0, 255, 1, 0, 4};
        ttl_plan[3] = $urandom_range(2, 254);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero id on empty slots, all-ones id, spare mode, expiry timing
        push_req(MODE_LOOKUP, 32'h0000_0000, 1'b0);
        push_req(MODE_LOOKUP, 32'h0000_0000, 1'b1);
        push_req(MODE_LOOKUP, 32'h0000_0000, 1'b0);
        push_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1);
        push_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        push_req(MODE_SPARE, 32'hFFFF_FFFF, 1'b1);
        push_req(MODE_LOOKUP, 32'h8000_0001, 1'b0);
        repeat (4) push_req(MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
        push_req(MODE_LOOKUP, 32'h0000_0000, 1'b1);
        repeat (5) push_req(MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
        push_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1);
        push_req(MODE_FLUSH, 32'h5A5A_5A5A, 1'b1);
        push_req(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        push_req(MODE_LOOKUP, 32'h7FFF_FFFE, 1'b1);
        push_req(MODE_SPARE, 32'h0000_0000, 1'b0);
        push_req(MODE_FLUSH, 32'hA5A5_A5A5, 1'b0);
        wait_idle();

        foreach (ttl_plan[p]) begin
            write_ttl(TTL_W'(ttl_plan[p]));
            refresh_pool();
            fill_episode();
            while (items_queued < 22 + (p + 1) * 275) mixed_episode();
            wait_idle();
        end
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests with ttl reload 4, 0, 255, 1, %0d and 4",
                 items_sent, ttl_plan[3]);
        $display("hits %0d, loads %0d, full %0d, failed loads %0d, tick/flush/spare %0d",
                 status_seen[ST_HIT], status_seen[ST_LOADED], status_seen[ST_NO_SPACE],
                 status_seen[ST_LOAD_FAIL], status_seen[ST_DONE]);
        if (fault_cnt == 0)
            $display("[ttl_file_cache_slots_unit] OK");
        else
            $display("[ttl_file_cache_slots_unit] ERROR");
        $finish;
    end

endmodule
